[src/temperature_setpoint_fan_drive_unit_assert.svh]
// Assertion macros for the temperature setpoint fan drive unit.
`ifndef TEMPERATURE_SETPOINT_FAN_DRIVE_UNIT_ASSERT_SVH
`define TEMPERATURE_SETPOINT_FAN_DRIVE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TSFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/tsfd_pkg.sv]
// Shared types and constants of the temperature setpoint fan drive unit.
`default_nettype none

package tsfd_pkg;

    typedef logic signed [14:0] reading_t;
    typedef logic [15:0]        compare_t;
    typedef logic [15:0]        bcd4_t;
    typedef logic [1:0]         digit_sel_t;

    typedef enum logic [1:0] {
        KEY_NONE = 2'd0,
        KEY_INC  = 2'd1,
        KEY_DEC  = 2'd2,
        KEY_NEXT = 2'd3
    } key_code_t;

    typedef enum logic [0:0] {
        CFG_BASE_COUNT = 1'd0,
        CFG_GAIN       = 1'd1
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    localparam bcd4_t       SP_RESET_BCD = 16'h2800;
    localparam compare_t    BASE_RESET   = 16'd250;
    localparam logic [7:0]  GAIN_RESET   = 8'd50;

    // Setpoint state as seen by the datapath.
    typedef struct packed {
        bcd4_t      bcd;
        digit_sel_t sel;
    } sp_state_t;

endpackage

`default_nettype wire

[src/tsfd_sample_if.sv]
// Input channel: key event and temperature reading of one control pass.
`default_nettype none

interface tsfd_sample_if
    import tsfd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] key_event;
    reading_t   reading_hundredths;

    modport source (output valid, output key_event, output reading_hundredths, input ready);
    modport sink   (input valid, input key_event, input reading_hundredths, output ready);
endinterface

`default_nettype wire

[src/tsfd_result_if.sv]
// Output channel: drive compares, LED and display digits of one control pass.
`default_nettype none

interface tsfd_result_if
    import tsfd_pkg::*;
();
    logic       valid;
    logic       ready;
    compare_t   cool_compare;
    compare_t   heat_compare;
    logic       heating_led;
    bcd4_t      setpoint_bcd;
    bcd4_t      reading_bcd;
    digit_sel_t edit_digit;

    modport source (output valid, output cool_compare, output heat_compare,
                    output heating_led, output setpoint_bcd, output reading_bcd,
                    output edit_digit, input ready);
    modport sink   (input valid, input cool_compare, input heat_compare,
                    input heating_led, input setpoint_bcd, input reading_bcd,
                    input edit_digit, output ready);
endinterface

`default_nettype wire

[src/temperature_setpoint_fan_drive_unit.sv]
// Top level: setpoint editing, temperature compare, PWM drive and display digits.
//
//  channel   dir  handshake         payload
//  sample    in   valid / ready     key_event, reading_hundredths
//  result    out  valid / ready     cool/heat compare, heating_led, setpoint/reading BCD,
//                                   edit_digit
//  cfg       in   cfg_write only    cfg_index, cfg_data (base_count, gain_per_degree)
//
// Five-stage pipeline, one transaction per cycle sustained while result.ready is high;
// a sample moves through the stage-1 to stage-4 registers into the output registers.
// The stage-4 23x25 multiply (divide by 100) and stage-3 gain multiply set stage depth.
// Reset clears pipeline valids, setpoint 28.00, digit 0, compares 0, LED 1.
// Each stage holds only while the one after it is full and stalled, so bubbles are
// squeezed out; while a result waits on result.ready, samples still fill empty stages.
`include "temperature_setpoint_fan_drive_unit_assert.svh"
`default_nettype none

module temperature_setpoint_fan_drive_unit
    import tsfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [0:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tsfd_sample_if.sink           sample,
    tsfd_result_if.source         result
);

    // reciprocal constants: floor(x/100) = (x*M) >> S, exact over the ranges used
    localparam logic [24:0] RECIP100_M = 25'd21474837;   // S = 31, x < 2^23
    localparam logic [13:0] RHI_M      = 14'd10486;      // S = 20, x < 10000

    // two BCD digits of a value 0..99
    function automatic logic [7:0] bcd2(input logic [6:0] v);
        logic [14:0] t;
        logic [3:0]  tens;
        logic [6:0]  units;
        t     = 15'(v) * 15'd205;
        tens  = t[14:11];
        units = v - 7'(tens) * 7'd10;
        return {tens, units[3:0]};
    endfunction

    // configuration
    compare_t   base_reg;
    logic [7:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BASE_COUNT: base_reg <= cfg_data;
                CFG_GAIN:       gain_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // stage flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic take1, take2, take3, take4, take5;
    logic in_fire;

    assign take5   = !out_valid_reg || result.ready;
    assign take4   = !v4_reg || take5;
    assign take3   = !v3_reg || take4;
    assign take2   = !v2_reg || take3;
    assign take1   = !v1_reg || take2;
    assign sample.ready = take1;
    assign in_fire = sample.valid && take1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1) v1_reg        <= sample.valid;
            if (take2) v2_reg        <= v1_reg;
            if (take3) v3_reg        <= v2_reg;
            if (take4) v4_reg        <= v3_reg;
            if (take5) out_valid_reg <= v4_reg;
        end
    end

    // stage 1: setpoint edit applied on accept; its registers are the stage-1 digits
    sp_state_t sp_state;
    reading_t  reading_s1_reg;

    tsfd_setpoint u_setpoint (
        .clk   (clk),
        .rst_n (rst_n),
        .apply (in_fire),
        .key   (sample.key_event),
        .state (sp_state)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            reading_s1_reg <= sample.reading_hundredths;
        end
    end

    // stage 2: setpoint to binary, compare, |error|, reading modulo 10000
    logic [12:0]        sp_bin;
    logic signed [15:0] rd_ext;
    logic signed [15:0] sp_ext;
    logic signed [15:0] diff_wide;
    logic               lt_next, gt_next;
    logic [13:0]        rmod_next;

    bcd4_t      sp_s2_reg;
    digit_sel_t sel_s2_reg;
    logic       lt_s2_reg, gt_s2_reg;
    logic [14:0] diff_s2_reg;
    logic [13:0] rmod_s2_reg;

    always_comb
    begin
        sp_bin = 13'(sp_state.bcd[15:12]) * 13'd1000 + 13'(sp_state.bcd[11:8]) * 13'd100
               + 13'(sp_state.bcd[7:4]) * 13'd10 + 13'(sp_state.bcd[3:0]);
        rd_ext    = 16'(reading_s1_reg);
        sp_ext    = signed'({3'b000, sp_bin});
        lt_next   = rd_ext < sp_ext;
        gt_next   = rd_ext > sp_ext;
        diff_wide = lt_next ? (sp_ext - rd_ext) : (rd_ext - sp_ext);
        // negative and zero readings show 0000
        if (rd_ext > 16'sd0)
        begin
            rmod_next = (rd_ext >= 16'sd10000) ? 14'(rd_ext - 16'sd10000) : 14'(rd_ext);
        end
        else
        begin
            rmod_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take2 && v1_reg)
        begin
            sp_s2_reg   <= sp_state.bcd;
            sel_s2_reg  <= sp_state.sel;
            lt_s2_reg   <= lt_next;
            gt_s2_reg   <= gt_next;
            diff_s2_reg <= diff_wide[14:0];
            rmod_s2_reg <= rmod_next;
        end
    end

    // stage 3: gain * error, hundreds of the reading
    logic [27:0] rhi_prod;

    bcd4_t      sp_s3_reg;
    digit_sel_t sel_s3_reg;
    logic       lt_s3_reg, gt_s3_reg;
    logic [22:0] prod_s3_reg;
    logic [13:0] rmod_s3_reg;
    logic [6:0]  rhi_s3_reg;

    assign rhi_prod = 28'(rmod_s2_reg) * 28'(RHI_M);

    always_ff @(posedge clk)
    begin
        if (take3 && v2_reg)
        begin
            sp_s3_reg   <= sp_s2_reg;
            sel_s3_reg  <= sel_s2_reg;
            lt_s3_reg   <= lt_s2_reg;
            gt_s3_reg   <= gt_s2_reg;
            prod_s3_reg <= 23'(gain_reg) * 23'(diff_s2_reg);
            rmod_s3_reg <= rmod_s2_reg;
            rhi_s3_reg  <= rhi_prod[26:20];
        end
    end

    // stage 4: divide by 100, reading digits
    logic [47:0] quot_prod;
    logic [13:0] rlo_wide;

    bcd4_t      sp_s4_reg;
    digit_sel_t sel_s4_reg;
    logic       lt_s4_reg, gt_s4_reg;
    compare_t   quot_s4_reg;
    bcd4_t      rbcd_s4_reg;

    assign quot_prod = 48'(prod_s3_reg) * 48'(RECIP100_M);
    assign rlo_wide  = rmod_s3_reg - 14'(rhi_s3_reg) * 14'd100;

    always_ff @(posedge clk)
    begin
        if (take4 && v3_reg)
        begin
            sp_s4_reg   <= sp_s3_reg;
            sel_s4_reg  <= sel_s3_reg;
            lt_s4_reg   <= lt_s3_reg;
            gt_s4_reg   <= gt_s3_reg;
            quot_s4_reg <= quot_prod[46:31];
            rbcd_s4_reg <= {bcd2(rhi_s3_reg), bcd2(rlo_wide[6:0])};
        end
    end

    // stage 5: offset, saturate, pick the side; equal readings keep the last drive
    logic [16:0] drive_sum;
    compare_t    drive;

    compare_t   cool_reg, cool_next;
    compare_t   heat_reg, heat_next;
    logic       led_reg, led_next;
    bcd4_t      sp_out_reg;
    bcd4_t      rbcd_out_reg;
    digit_sel_t sel_out_reg;

    always_comb
    begin
        drive_sum = 17'(base_reg) + 17'(quot_s4_reg);
        drive     = drive_sum[16] ? 16'hFFFF : drive_sum[15:0];
        cool_next = cool_reg;
        heat_next = heat_reg;
        led_next  = led_reg;
        if (gt_s4_reg)
        begin
            cool_next = drive;
            heat_next = '0;
            led_next  = 1'b1;
        end
        else if (lt_s4_reg)
        begin
            cool_next = '0;
            heat_next = drive;
            led_next  = 1'b0;
        end
    end

    // output registers double as the held drive state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cool_reg <= '0;
            heat_reg <= '0;
            led_reg  <= 1'b1;
        end
        else if (take5 && v4_reg)
        begin
            cool_reg <= cool_next;
            heat_reg <= heat_next;
            led_reg  <= led_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take5 && v4_reg)
        begin
            sp_out_reg   <= sp_s4_reg;
            rbcd_out_reg <= rbcd_s4_reg;
            sel_out_reg  <= sel_s4_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.cool_compare = cool_reg;
    assign result.heat_compare = heat_reg;
    assign result.heating_led  = led_reg;
    assign result.setpoint_bcd = sp_out_reg;
    assign result.reading_bcd  = rbcd_out_reg;
    assign result.edit_digit   = sel_out_reg;

    // checks
    `TSFD_ASSERT_NOW(a_one_side_driven, clk, rst_n, 1'b1, (cool_reg == '0) || (heat_reg == '0), "both drive channels active")
    `TSFD_ASSERT_NOW(a_led_matches_side, clk, rst_n, led_reg, heat_reg == '0, "heater driven while LED shows cooling side")
    `TSFD_ASSERT_NOW(a_setpoint_limit, clk, rst_n, 1'b1, sp_state.bcd <= 16'h5000, "setpoint above 50.00")
    `TSFD_ASSERT_NEXT(a_next_digit, clk, rst_n, in_fire && (sample.key_event == KEY_NEXT), sp_state.sel == $past(sp_state.sel) + 2'd1, "digit select did not advance")

endmodule

`default_nettype wire

[src/tsfd_setpoint.sv]
// BCD setpoint editor: digit select, carry/borrow, floor at 00.00, clamp at 50.00.
`default_nettype none

module tsfd_setpoint
    import tsfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       apply,
    input  logic [1:0] key,
    output sp_state_t  state
);

    bcd4_t             bcd_reg;
    bcd4_t             bcd_next;
    digit_sel_t        sel_reg;
    digit_sel_t        sel_next;
    logic signed [5:0] d [4];
    logic              over;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            d[i] = signed'({2'b00, bcd_reg[15 - 4*i -: 4]});
        end
        sel_next = sel_reg;
        case (key_code_t'(key))
            KEY_INC:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (2'(i) == sel_reg)
                    begin
                        d[i] = d[i] + 6'sd1;
                    end
                end
            end
            KEY_DEC:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    if (2'(i) == sel_reg)
                    begin
                        d[i] = d[i] - 6'sd1;
                    end
                end
            end
            KEY_NEXT: sel_next = sel_reg + 2'd1;
            KEY_NONE: ;
            default: ;
        endcase
        // carry then borrow, hundredths upward
        for (int i = 3; i >= 1; i--)
        begin
            if (d[i] >= 6'sd10)
            begin
                d[i]     = 6'sd0;
                d[i - 1] = d[i - 1] + 6'sd1;
            end
        end
        for (int i = 3; i >= 1; i--)
        begin
            if (d[i] < 6'sd0)
            begin
                d[i]     = 6'sd9;
                d[i - 1] = d[i - 1] - 6'sd1;
            end
        end
        if (d[0] < 6'sd0)
        begin
            for (int i = 0; i < 4; i++)
            begin
                d[i] = 6'sd0;
            end
        end
        over = (d[0] > 6'sd5)
            || ((d[0] == 6'sd5) && ((d[1] != 6'sd0) || (d[2] != 6'sd0) || (d[3] != 6'sd0)));
        if (over)
        begin
            d[0] = 6'sd5;
            d[1] = 6'sd0;
            d[2] = 6'sd0;
            d[3] = 6'sd0;
        end
        bcd_next = {d[0][3:0], d[1][3:0], d[2][3:0], d[3][3:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcd_reg <= SP_RESET_BCD;
            sel_reg <= '0;
        end
        else if (apply)
        begin
            bcd_reg <= bcd_next;
            sel_reg <= sel_next;
        end
    end

    assign state.bcd = bcd_reg;
    assign state.sel = sel_reg;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the temperature setpoint fan drive unit.
`default_nettype none

module tb_top
    import tsfd_pkg::*;
();

    // Run length guard, sized far above the slowest legal run (about 1400
    // transactions at heavy idling on both sides plus the long hold-off).
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Pipeline is five deep; the drain wait settles after the last result has arrived.
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int          READING_MIN  = -5500;
    localparam int          READING_MAX  = 12500;

    // One expected result of a control pass, laid out like the result channel.
    typedef struct packed {
        compare_t   cool;
        compare_t   heat;
        logic       led;
        bcd4_t      sp_bcd;
        bcd4_t      rd_bcd;
        digit_sel_t sel;
    } pass_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [0:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tsfd_sample_if sample_ch ();
    tsfd_result_if result_ch ();

    temperature_setpoint_fan_drive_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Bench copy of the block state: setpoint digits (tens first), the
    // digit under edit, the held drive outputs and the two registers.
    // ------------------------------------------------------------------
    int           sp_digit [4];
    digit_sel_t   edit_sel;
    compare_t     cool_hold;
    compare_t     heat_hold;
    logic         led_hold;
    compare_t     base_cfg;
    logic [7:0]   gain_cfg;

    pass_result_t pending_results[$];

    // Idle knobs, in percent, changed only between phases.
    int unsigned  gap_pct   = 0;
    int unsigned  stall_pct = 0;
    logic         hold_request = 1'b0;

    int unsigned  cycle_count    = 0;
    int unsigned  mismatch_count = 0;
    int unsigned  passes_sent    = 0;
    int unsigned  results_seen   = 0;
    int unsigned  equal_passes   = 0;
    int unsigned  settings_used  = 0;

    function automatic int setpoint_hundredths();
        return 1000 * sp_digit[0] + 100 * sp_digit[1] + 10 * sp_digit[2] + sp_digit[3];
    endfunction

    // Active channel value: offset plus truncated gain term, pinned at full scale.
    function automatic compare_t drive_for(int unsigned diff);
        int unsigned v;
        v = int'(base_cfg) + (int'(gain_cfg) * diff) / 100;
        return (v > 65535) ? 16'hFFFF : compare_t'(v);
    endfunction

    // Advance the bench state by one control pass and return what the block
    // must report for it.
    function automatic pass_result_t predict_pass(key_code_t key, reading_t rd);
        int           d [4];
        int           i;
        int           sp;
        int           temp;
        int           r;
        pass_result_t res;
        for (i = 0; i < 4; i++)
            d[i] = sp_digit[i];
        case (key)
            KEY_INC:  d[edit_sel] = d[edit_sel] + 1;
            KEY_DEC:  d[edit_sel] = d[edit_sel] - 1;
            KEY_NEXT: edit_sel = edit_sel + 2'd1;   // wraps 3 -> 0
            default: ;
        endcase
        // carries ripple from hundredths upward, then borrows the same way
        for (i = 3; i >= 1; i--)
            if (d[i] >= 10) begin
                d[i] = 0;
                d[i-1] = d[i-1] + 1;
            end
        for (i = 3; i >= 1; i--)
            if (d[i] < 0) begin
                d[i] = 9;
                d[i-1] = d[i-1] - 1;
            end
        // borrow out of tens: floor at 00.00
        if (d[0] < 0)
            for (i = 0; i < 4; i++)
                d[i] = 0;
        // anything over 50.00, carry out of tens included, pins at 50.00
        if (1000 * d[0] + 100 * d[1] + 10 * d[2] + d[3] > 5000) begin
            d[0] = 5;
            for (i = 1; i < 4; i++)
                d[i] = 0;
        end
        for (i = 0; i < 4; i++)
            sp_digit[i] = d[i] & 15;

        sp   = setpoint_hundredths();
        temp = int'(rd);
        if (temp < sp) begin
            led_hold  = 1'b0;
            cool_hold = '0;
            heat_hold = drive_for(sp - temp);
        end
        else if (temp > sp) begin
            led_hold  = 1'b1;
            cool_hold = drive_for(temp - sp);
            heat_hold = '0;
        end
        else
            equal_passes++;   // outputs keep their last values

        res.rd_bcd = '0;      // zero and negative readings show 0000
        if (temp > 0) begin
            r = temp % 10000; // hundreds of degrees drop off the display
            res.rd_bcd = bcd4_t'(((r / 1000) << 12) | (((r / 100) % 10) << 8)
                                 | (((r / 10) % 10) << 4) | (r % 10));
        end
        res.cool   = cool_hold;
        res.heat   = heat_hold;
        res.led    = led_hold;
        res.sp_bcd = bcd4_t'((sp_digit[0] << 12) | (sp_digit[1] << 8)
                             | (sp_digit[2] << 4) | sp_digit[3]);
        res.sel    = edit_sel;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sample side. Valid stays up across back-to-back transactions; the
    // prediction is made at the edge where the block takes the pass.
    // ------------------------------------------------------------------
    task automatic send_pass(key_code_t key, reading_t rd);
        while ($urandom_range(99) < gap_pct) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid              <= 1'b1;
        sample_ch.key_event          <= key;
        sample_ch.reading_hundredths <= rd;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_pass(key, rd));
        passes_sent++;
    endtask

    // Random pass: a share of readings sits on or near the setpoint so the
    // hold-on-equal path and small errors get exercised, the rest spans the
    // whole sensor range.
    task automatic send_random_pass();
        key_code_t key;
        int        sp;
        int        rd_i;
        key = key_code_t'(2'($urandom_range(3)));
        sp  = setpoint_hundredths();
        case ($urandom_range(9))
            0: begin
                key  = KEY_NONE;
                rd_i = sp;
            end
            1, 2, 3: rd_i = sp + int'($urandom_range(600)) - 300;
            default: rd_i = READING_MIN + int'($urandom_range(READING_MAX - READING_MIN));
        endcase
        if (rd_i < READING_MIN)
            rd_i = READING_MIN;
        if (rd_i > READING_MAX)
            rd_i = READING_MAX;
        send_pass(key, reading_t'(rd_i));
    endtask

    // Stop offering, let every outstanding result arrive, then settle.
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers are written back to back; only called with the block idle.
    task automatic apply_settings(compare_t base, logic [7:0] gain);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BASE_COUNT;
        cfg_data  <= base;
        @(posedge clk);
        cfg_index <= CFG_GAIN;
        cfg_data  <= CFG_DATA_W'(gain);
        @(posedge clk);
        cfg_write <= 1'b0;
        base_cfg = base;
        gain_cfg = gain;
        settings_used++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request that
    // this process counts down itself.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every accepted result transaction is matched against the oldest prediction.
    always @(posedge clk) begin : result_check
        pass_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transaction with no pass outstanding");
                mismatch_count++;
            end
            else begin
                want = pending_results.pop_front();
                check_field("cool_compare", want.cool,   result_ch.cool_compare);
                check_field("heat_compare", want.heat,   result_ch.heat_compare);
                check_field("heating_led",  want.led,    result_ch.heating_led);
                check_field("setpoint_bcd", want.sp_bcd, result_ch.setpoint_bcd);
                check_field("reading_bcd",  want.rd_bcd, result_ch.reading_bcd);
                check_field("edit_digit",   want.sel,    result_ch.edit_digit);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset: setpoint 28.00, tens selected, registers at defaults.
    task automatic test_directed_edges();
        send_pass(KEY_NONE, 15'sd2800);      // equal straight out of reset: zeros held, LED on
        send_pass(KEY_NONE, 15'sd12500);     // hottest reading, display wraps to 25.00
        send_pass(KEY_NONE, -15'sd5500);     // coldest reading, display 0000
        send_pass(KEY_NONE, 15'sd2800);      // equal again: heat drive held
        send_pass(KEY_NONE, 15'sd10000);     // 100.00 loses its top digit
        send_pass(KEY_NEXT, 15'sd2700);
        send_pass(KEY_NEXT, 15'sd2900);
        send_pass(KEY_NEXT, 15'sd2801);      // hundredths selected
        send_pass(KEY_DEC,  15'sd2800);      // borrow chain to 27.99
        send_pass(KEY_INC,  15'sd2800);      // carry chain back to 28.00, equal
        send_pass(KEY_NEXT, 15'sd1);         // selection wraps to tens
        send_pass(KEY_DEC,  15'sd1800);
        send_pass(KEY_DEC,  15'sd900);
        send_pass(KEY_DEC,  15'sd0);         // borrow out of tens floors at 00.00
        send_pass(KEY_DEC,  -15'sd1);        // already at zero, stays there
        send_pass(KEY_INC,  15'sd1000);
        send_pass(KEY_INC,  15'sd2000);
        send_pass(KEY_INC,  15'sd3000);
        send_pass(KEY_INC,  15'sd4000);
        send_pass(KEY_INC,  15'sd5000);      // exactly at the 50.00 limit
        send_pass(KEY_INC,  15'sd6000);      // tens to 6: pinned at 50.00
        send_pass(KEY_NEXT, 15'sd5001);
        send_pass(KEY_NEXT, 15'sd4999);
        send_pass(KEY_NEXT, 15'sd5000);
        send_pass(KEY_INC,  15'sd5000);      // 50.01 pinned back to 50.00
        wait_for_results();
    endtask

    // Register extremes: no drive offset and no gain, then both at full scale.
    task automatic test_config_extremes();
        int i;
        apply_settings('0, 8'd0);
        for (i = 0; i < 40; i++)
            send_random_pass();
        wait_for_results();
        apply_settings(16'hFFFF, 8'hFF);
        for (i = 0; i < 40; i++)
            send_random_pass();
        wait_for_results();
    endtask

    // Bulk random traffic under each idling pattern, fresh registers per phase.
    task automatic test_random_phases();
        int unsigned send_gap [4];
        int unsigned sink_gap [4];
        int          p;
        int          i;
        compare_t    base;
        send_gap = '{0, 79, 0, 24};
        sink_gap = '{0, 0, 79, 24};
        for (p = 0; p < 4; p++) begin
            base = ($urandom_range(3) == 0) ? compare_t'($urandom_range(65535))
                                            : compare_t'($urandom_range(2000));
            apply_settings(base, 8'($urandom_range(255)));
            gap_pct   = send_gap[p];
            stall_pct = sink_gap[p];
            for (i = 0; i < 315; i++)
                send_random_pass();
            wait_for_results();
        end
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    // Receiver holds off for a long stretch while passes keep coming, so the
    // pipeline fills and the sample side has to stall.
    task automatic test_backpressure();
        int i;
        apply_settings(BASE_RESET, GAIN_RESET);
        hold_request <= 1'b1;
        for (i = 0; i < 40; i++)
            send_random_pass();
        wait_for_results();
    endtask

    initial begin
        int i;
        rst_n                        = 1'b0;
        cfg_write                    = 1'b0;
        cfg_index                    = CFG_BASE_COUNT;
        cfg_data                     = '0;
        sample_ch.valid              = 1'b0;
        sample_ch.key_event          = KEY_NONE;
        sample_ch.reading_hundredths = '0;

        // reset image of the bench state
        for (i = 0; i < 4; i++)
            sp_digit[i] = int'(SP_RESET_BCD[15 - 4*i -: 4]);
        edit_sel  = '0;
        cool_hold = '0;
        heat_hold = '0;
        led_hold  = 1'b1;
        base_cfg  = BASE_RESET;
        gain_cfg  = GAIN_RESET;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_config_extremes();
        test_random_phases();
        test_backpressure();

        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            mismatch_count++;
        end
        $display("Covered %0d control passes (%0d at equal temperature) and %0d results",
                 passes_sent, equal_passes, results_seen);
        $display("across %0d register settings, four idling patterns and one long hold-off.",
                 settings_used);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire
